/* rtl/bnfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnfa_pkg
// Shared widths, codes and controller/datapath interface structs for the
// next-fit block allocator.
// ----------------------------------------------------------------------------
package bnfa_pkg;

  localparam int unsigned SIZE_W    = 17;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned USED_W    = 11;
  localparam int unsigned MARK_W    = 3;

  // block marks
  localparam logic [MARK_W-1:0] MARK_FREE   = 3'd0;
  localparam logic [MARK_W-1:0] MARK_USED   = 3'd1;
  localparam logic [MARK_W-1:0] MARK_START  = 3'd2;
  localparam logic [MARK_W-1:0] MARK_END    = 3'd3;
  localparam logic [MARK_W-1:0] MARK_SINGLE = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_SIZE = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_RUN    = 3'd3;
  localparam logic [STAT_W-1:0] ST_FREE_IGN  = 3'd4;

  // request kinds
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic              load;       // latch request, block count or index
    logic              scan_init;  // cursor <= pointer, first pass
    logic              scan_adv;   // cursor++, run count update
    logic              scan_wrap;  // cursor <= 0, second pass
    logic              scan_hit;   // run found, set run start
    logic              free_init;  // cursor <= freed block index
    logic              run_step;   // write one mark of the run
    logic              commit;     // update count, pointer, address
    logic              sweep;      // post-reset clear of the mark store
    logic              out_load;
    logic [STAT_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic func;
    logic need_zero;
    logic need_big;
    logic free_bad;
    logic hit;
    logic pass_end;
    logic pass2;
    logic ptr_zero;
    logic is_single;
    logic is_start;
    logic is_end;
    logic at_last;
    logic run_done;
    logic out_free;
  } sts_t;

endpackage

/* rtl/bnfa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnfa_ctrl
// Sequencer for the allocator: clear sweep, request check, run search,
// mark write-back and response handoff.
// ----------------------------------------------------------------------------
module bnfa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  bnfa_pkg::sts_t sts_i,
  output bnfa_pkg::cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b000_0000_0001,
    S_IDLE    = 11'b000_0000_0010,
    S_CHECK   = 11'b000_0000_0100,
    S_SCAN_RD = 11'b000_0000_1000,
    S_SCAN_EV = 11'b000_0001_0000,
    S_FREE_RD = 11'b000_0010_0000,
    S_FREE_EV = 11'b000_0100_0000,
    S_END_RD  = 11'b000_1000_0000,
    S_END_EV  = 11'b001_0000_0000,
    S_RUN     = 11'b010_0000_0000,
    S_RESP    = 11'b100_0000_0000
  } state_e;

  state_e                       state_q, state_d;
  logic [bnfa_pkg::STAT_W-1:0]  code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      code_q  <= bnfa_pkg::ST_DONE;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    cmd_o.status = code_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.func == bnfa_pkg::FUNC_ALLOC) begin
          if (sts_i.need_zero) begin
            code_d  = bnfa_pkg::ST_ZERO_SIZE;
            state_d = S_RESP;
          end else if (sts_i.need_big) begin
            code_d  = bnfa_pkg::ST_NO_SPACE;
            state_d = S_RESP;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN_RD;
          end
        end else begin
          if (sts_i.free_bad) begin
            code_d  = bnfa_pkg::ST_FREE_IGN;
            state_d = S_RESP;
          end else begin
            cmd_o.free_init = 1'b1;
            state_d         = S_FREE_RD;
          end
        end
      end
      S_SCAN_RD: state_d = S_SCAN_EV;
      S_SCAN_EV: begin
        if (sts_i.hit) begin
          cmd_o.scan_hit = 1'b1;
          state_d        = S_RUN;
        end else if (sts_i.pass_end) begin
          if (!sts_i.pass2 && !sts_i.ptr_zero) begin
            cmd_o.scan_wrap = 1'b1;
            state_d         = S_SCAN_RD;
          end else begin
            code_d  = bnfa_pkg::ST_NO_RUN;
            state_d = S_RESP;
          end
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d        = S_SCAN_RD;
        end
      end
      S_FREE_RD: state_d = S_FREE_EV;
      S_FREE_EV: begin
        if (sts_i.is_single) begin
          state_d = S_RUN;
        end else if (sts_i.is_start) begin
          state_d = S_END_RD;
        end else begin
          code_d  = bnfa_pkg::ST_FREE_IGN;
          state_d = S_RESP;
        end
      end
      S_END_RD: state_d = S_END_EV;
      S_END_EV: begin
        if (sts_i.is_end) begin
          state_d = S_RUN;
        end else if (sts_i.at_last) begin
          // start mark with no end mark behind it
          code_d  = bnfa_pkg::ST_FREE_IGN;
          state_d = S_RESP;
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d        = S_END_RD;
        end
      end
      S_RUN: begin
        cmd_o.run_step = 1'b1;
        if (sts_i.run_done) begin
          cmd_o.commit = 1'b1;
          code_d       = bnfa_pkg::ST_DONE;
          state_d      = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

/* rtl/bnfa_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnfa_dp
// Allocator datapath: mark store, block count and index shift, scan cursor
// and run counter, usage count, next-fit pointer and output register.
// ----------------------------------------------------------------------------
module bnfa_dp #(
  parameter int unsigned NUM_BLOCKS  = 1024,
  parameter int unsigned BLOCK_BYTES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bnfa_pkg::cmd_t                cmd_i,
  output bnfa_pkg::sts_t                sts_o,
  input  logic                          req_func_i,
  input  logic [bnfa_pkg::SIZE_W-1:0]   req_size_i,
  input  logic [bnfa_pkg::ADDR_W-1:0]   req_addr_i,
  input  logic                          cfg_we_i,
  input  logic [bnfa_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [bnfa_pkg::STAT_W-1:0]   out_status_o,
  output logic [bnfa_pkg::ADDR_W-1:0]   out_addr_o,
  output logic [bnfa_pkg::USED_W-1:0]   out_used_o
);

  localparam int unsigned IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned RB = $clog2(BLOCK_BYTES);
  localparam int unsigned UW = (CW > bnfa_pkg::USED_W) ? CW : bnfa_pkg::USED_W;
  localparam int unsigned AW = bnfa_pkg::ADDR_W;
  localparam int unsigned SW = bnfa_pkg::SIZE_W + 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(NUM_BLOCKS - 1);

  // mark store
  logic [bnfa_pkg::MARK_W-1:0] marks [NUM_BLOCKS];
  logic [bnfa_pkg::MARK_W-1:0] rdata_q;
  logic                        mem_we;
  logic [bnfa_pkg::MARK_W-1:0] mem_wdata;

  logic [AW-1:0]      base_q;
  logic               func_q;
  logic               below_q;
  logic [AW-1:0]      quo_q;
  logic [RB-1:0]      rem_q;
  logic [IW-1:0]      ptr_q, cursor_q, at_q, wcur_q;
  logic               pass_q;
  logic [CW-1:0]      used_q, run_q;
  logic [AW-1:0]      res_addr_q;

  logic               out_valid_q;
  logic [bnfa_pkg::STAT_W-1:0] out_status_q;
  logic [AW-1:0]      out_addr_q;
  logic [bnfa_pkg::USED_W-1:0] out_used_q;

  // blocks needed (size rounded up) or block index and offset remainder
  logic [SW-1:0]      size_rnd;
  logic [AW-1:0]      offset;
  logic [AW-1:0]      blk_sel;

  logic [CW-1:0]      need_c, avail, run_inc, run_cnt;
  logic [IW:0]        cur_inc, at_calc;
  logic               rd_free;
  logic [UW-1:0]      used_ext;

  assign size_rnd = {1'b0, req_size_i} + SW'(BLOCK_BYTES - 1);
  assign offset   = req_addr_i - base_q;
  assign blk_sel  = (req_func_i == bnfa_pkg::FUNC_FREE) ? (offset >> RB)
                    : AW'(size_rnd >> RB);

  assign need_c  = quo_q[CW-1:0];
  assign avail   = CW'(NUM_BLOCKS) - used_q;
  assign run_inc = run_q + CW'(1);
  assign run_cnt = CW'(cursor_q - at_q) + CW'(1);
  assign cur_inc = {1'b0, cursor_q} + (IW+1)'(1);
  assign at_calc = cur_inc - (IW+1)'(need_c);
  assign rd_free = (rdata_q == bnfa_pkg::MARK_FREE);
  assign used_ext = UW'(used_q);

  always_comb begin
    sts_o            = '0;
    sts_o.sweep_done = (wcur_q == IDX_LAST);
    sts_o.func       = func_q;
    sts_o.need_zero  = (quo_q == '0);
    sts_o.need_big   = (quo_q > AW'(avail));
    sts_o.free_bad   = below_q || (rem_q != '0) || (quo_q >= AW'(NUM_BLOCKS));
    sts_o.hit        = rd_free && (run_inc == need_c);
    sts_o.pass_end   = pass_q ? (cursor_q == ptr_q - IW'(1)) : (cursor_q == IDX_LAST);
    sts_o.pass2      = pass_q;
    sts_o.ptr_zero   = (ptr_q == '0);
    sts_o.is_single  = (rdata_q == bnfa_pkg::MARK_SINGLE);
    sts_o.is_start   = (rdata_q == bnfa_pkg::MARK_START);
    sts_o.is_end     = (rdata_q == bnfa_pkg::MARK_END);
    sts_o.at_last    = (cursor_q == IDX_LAST);
    sts_o.run_done   = (wcur_q == cursor_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // mark written for the current run position
  always_comb begin
    mem_we    = cmd_i.sweep || cmd_i.run_step;
    mem_wdata = bnfa_pkg::MARK_FREE;
    if (cmd_i.run_step && func_q == bnfa_pkg::FUNC_ALLOC) begin
      if (at_q == cursor_q)        mem_wdata = bnfa_pkg::MARK_SINGLE;
      else if (wcur_q == at_q)     mem_wdata = bnfa_pkg::MARK_START;
      else if (wcur_q == cursor_q) mem_wdata = bnfa_pkg::MARK_END;
      else                         mem_wdata = bnfa_pkg::MARK_USED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) marks[wcur_q] <= mem_wdata;
    rdata_q <= marks[cursor_q];
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q     <= req_func_i;
      below_q    <= (req_addr_i < base_q);
      quo_q      <= blk_sel;
      rem_q      <= offset[RB-1:0];
      res_addr_q <= '0;
    end
    if (cmd_i.commit && func_q == bnfa_pkg::FUNC_ALLOC)
      res_addr_q <= base_q + AW'(at_q) * AW'(BLOCK_BYTES);
    if (cmd_i.scan_init || cmd_i.scan_wrap) run_q <= '0;
    else if (cmd_i.scan_adv)                run_q <= rd_free ? run_inc : '0;
    if (cmd_i.scan_init) pass_q <= 1'b0;
    else if (cmd_i.scan_wrap) pass_q <= 1'b1;
    if (cmd_i.scan_hit) at_q <= at_calc[IW-1:0];
    else if (cmd_i.free_init) at_q <= quo_q[IW-1:0];
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.status;
      out_addr_q   <= res_addr_q;
      out_used_q   <= used_ext[bnfa_pkg::USED_W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      ptr_q       <= '0;
      used_q      <= '0;
      cursor_q    <= '0;
      wcur_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) base_q <= cfg_wdata_i;

      if (cmd_i.scan_init)      cursor_q <= ptr_q;
      else if (cmd_i.scan_wrap) cursor_q <= '0;
      else if (cmd_i.scan_adv)  cursor_q <= cursor_q + IW'(1);
      else if (cmd_i.free_init) cursor_q <= quo_q[IW-1:0];

      if (cmd_i.sweep || cmd_i.run_step) wcur_q <= wcur_q + IW'(1);
      else if (cmd_i.scan_hit)           wcur_q <= at_calc[IW-1:0];
      else if (cmd_i.free_init)          wcur_q <= quo_q[IW-1:0];

      if (cmd_i.commit) begin
        if (func_q == bnfa_pkg::FUNC_ALLOC) begin
          used_q <= used_q + need_c;
          ptr_q  <= (cur_inc == (IW+1)'(NUM_BLOCKS)) ? '0 : cur_inc[IW-1:0];
        end else begin
          used_q <= (used_q > run_cnt) ? (used_q - run_cnt) : '0;
        end
      end

      if (cmd_i.out_load)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_addr_o   = out_addr_q;
  assign out_used_o   = out_used_q;

endmodule

/* rtl/bitmap_next_fit_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_next_fit_block_allocator
// Next-fit heap allocator over NUM_BLOCKS blocks of BLOCK_BYTES bytes.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser selects allocate (0) or
// free (1), tdata carries the byte size and the address to release. Each
// request gives exactly one transfer on m_axis: status in tuser, granted
// address and blocks in use in tdata. The user writes heap_base through
// cfg_we_i/cfg_wdata_i only while idle; the block itself does not enforce it.
// After reset the mark store is swept free, one block a cycle, and
// s_axis_tready stays low until the sweep is done.
// Per request: an accept state and a check state, then a mark read and an
// evaluate state for each block scanned (at most NUM_BLOCKS blocks over
// both passes), or for a free a read and an evaluate of the addressed mark
// and of each block walked to the end mark, then one mark written per
// cycle, then the output register is loaded once it is free.
// One request is in flight at a time; the next is taken once the result
// sits in the output register. If m_axis stalls, the result waits there
// and a following request is processed but held until the register frees.
// ----------------------------------------------------------------------------
module bitmap_next_fit_block_allocator #(
  parameter int unsigned NUM_BLOCKS  = 1024,
  parameter int unsigned BLOCK_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // [16:0] size_bytes, [48:17] free_address
  input  logic [0:0]  s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] alloc_address, [42:32] used_blocks
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  bnfa_pkg::cmd_t                cmd;
  bnfa_pkg::sts_t                sts;
  logic [bnfa_pkg::ADDR_W-1:0]   out_addr;
  logic [bnfa_pkg::USED_W-1:0]   out_used;

  bnfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bnfa_dp #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_func_i   (s_axis_tuser[0]),
    .req_size_i   (s_axis_tdata[16:0]),
    .req_addr_i   (s_axis_tdata[48:17]),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_addr_o   (out_addr),
    .out_used_o   (out_used)
  );

  assign m_axis_tdata = {5'd0, out_used, out_addr};

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the next-fit block allocator. A local allocator
// model (marks, search pointer, used count, heap base) predicts status,
// granted address and blocks in use for every accepted request; results on
// m_axis are compared in order. Directed cases first, then random
// alloc/free traffic under several heap_base settings, random idling on
// both streams, a long output stall and drain pauses.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned NBLK          = 1024;
  localparam int unsigned BLK_BYTES     = 64;
  localparam int unsigned SLOW_CYCLES   = 3 * NBLK + 40;
  localparam int unsigned HOLD_CYCLES   = 2500;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [bnfa_pkg::STAT_W-1:0] status;
    logic [bnfa_pkg::ADDR_W-1:0] addr;
    logic [bnfa_pkg::USED_W-1:0] used;
  } alloc_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // [16:0] size_bytes, [48:17] free_address
  logic [0:0]  s_axis_tuser;   // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [31:0] alloc_address, [42:32] used_blocks
  logic [2:0]  m_axis_tuser;   // [2:0] status
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  // allocator model state
  logic [bnfa_pkg::MARK_W-1:0] blk_mark [NBLK];
  int unsigned       ptr_m;
  int unsigned       used_m;
  logic [31:0]       base_m;

  alloc_result_t expected_results [$];
  int unsigned   errors;
  int unsigned   results_seen;
  int unsigned   status_count [5];
  bit            steady;
  bit            hold_req;

  bitmap_next_fit_block_allocator #(
    .NUM_BLOCKS (NBLK),
    .BLOCK_BYTES(BLK_BYTES)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("timeout at %0t", $time);
    $display("tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic bit seek_free_run(int unsigned lo, int unsigned hi,
                                       int unsigned need, output int unsigned at);
    int unsigned run;
    int unsigned i;
    run = 0;
    at  = 0;
    for (i = lo; i < hi && i < NBLK; i++) begin
      if (blk_mark[i] == bnfa_pkg::MARK_FREE) begin
        run++;
        if (run == need) begin
          at = i + 1 - need;
          return 1'b1;
        end
      end else begin
        run = 0;
      end
    end
    return 1'b0;
  endfunction

  function automatic alloc_result_t predict_request(logic func, logic [16:0] size,
                                                    logic [31:0] faddr);
    alloc_result_t r;
    int unsigned   need;
    int unsigned   avail;
    int unsigned   idx;
    int unsigned   k;
    int unsigned   last;
    logic [31:0]   off;
    bit            found;
    r.status = bnfa_pkg::ST_DONE;
    r.addr   = '0;
    if (func == bnfa_pkg::FUNC_ALLOC) begin
      need  = (int'(size) + BLK_BYTES - 1) / BLK_BYTES;
      avail = (used_m < NBLK) ? NBLK - used_m : 0;
      if (need == 0) begin
        r.status = bnfa_pkg::ST_ZERO_SIZE;
      end else if (need > avail) begin
        r.status = bnfa_pkg::ST_NO_SPACE;
      end else begin
        found = seek_free_run(ptr_m, NBLK, need, idx);
        if (!found) found = seek_free_run(0, ptr_m, need, idx);
        if (!found) begin
          r.status = bnfa_pkg::ST_NO_RUN;
        end else begin
          for (k = 0; k < need; k++) blk_mark[idx + k] = bnfa_pkg::MARK_USED;
          if (need == 1) begin
            blk_mark[idx] = bnfa_pkg::MARK_SINGLE;
          end else begin
            blk_mark[idx]            = bnfa_pkg::MARK_START;
            blk_mark[idx + need - 1] = bnfa_pkg::MARK_END;
          end
          used_m += need;
          ptr_m  = (idx + need) % NBLK;
          r.addr = base_m + idx * BLK_BYTES;
        end
      end
    end else begin
      off = faddr - base_m;
      idx = off / BLK_BYTES;
      if (faddr < base_m || (off % BLK_BYTES) != 0 || off / BLK_BYTES >= NBLK) begin
        r.status = bnfa_pkg::ST_FREE_IGN;
      end else if (blk_mark[idx] == bnfa_pkg::MARK_SINGLE) begin
        blk_mark[idx] = bnfa_pkg::MARK_FREE;
        if (used_m > 0) used_m--;
      end else if (blk_mark[idx] != bnfa_pkg::MARK_START) begin
        r.status = bnfa_pkg::ST_FREE_IGN;
      end else begin
        last = idx;
        while (last < NBLK && blk_mark[last] != bnfa_pkg::MARK_END) last++;
        if (last >= NBLK) begin
          r.status = bnfa_pkg::ST_FREE_IGN;
        end else begin
          for (k = idx; k <= last; k++) blk_mark[k] = bnfa_pkg::MARK_FREE;
          used_m = (used_m > last - idx + 1) ? used_m - (last - idx + 1) : 0;
        end
      end
    end
    r.used = used_m[bnfa_pkg::USED_W-1:0];
    return r;
  endfunction

  // start address of some live allocation, searched from a random block
  function automatic bit live_address(output logic [31:0] a);
    int unsigned r;
    int unsigned k;
    int unsigned i;
    r = $urandom_range(NBLK - 1);
    a = '0;
    for (k = 0; k < NBLK; k++) begin
      i = (r + k) % NBLK;
      if (blk_mark[i] == bnfa_pkg::MARK_START || blk_mark[i] == bnfa_pkg::MARK_SINGLE) begin
        a = base_m + i * BLK_BYTES;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic send_req(logic func, logic [16:0] size, logic [31:0] faddr);
    if (!steady && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, faddr, size};
    s_axis_tuser  <= func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(predict_request(func, size, faddr));
  endtask

  // the unused field of each request carries junk
  task automatic send_alloc(logic [16:0] size);
    send_req(bnfa_pkg::FUNC_ALLOC, size, $urandom);
  endtask

  task automatic send_free(logic [31:0] faddr);
    send_req(bnfa_pkg::FUNC_FREE, 17'($urandom_range(0, 131071)), faddr);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_heap_base(logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    base_m = value;
  endtask

  task automatic test_directed();
    // wait out the post-reset sweep
    while (!s_axis_tready) @(posedge clk_i);
    write_heap_base(32'd0);
    send_alloc(17'd0);                  // zero size
    send_alloc(17'd65536);              // whole heap, granted at address zero
    send_alloc(17'd1);                  // heap full
    send_alloc(17'h1FFFF);              // beyond the heap
    send_free(32'd0);
    send_alloc(17'd32768);              // 512 blocks at 0
    send_alloc(17'd64);                 // single at 512
    send_alloc(17'd32704);              // 511 blocks to the last block, pointer wraps
    send_free(32'd0);
    send_free(32'd513 * BLK_BYTES);
    send_alloc(17'(600 * BLK_BYTES));   // enough free, no contiguous run
    send_free(32'd513 * BLK_BYTES);     // free mark
    send_free(32'd512 * BLK_BYTES + 1); // misaligned
    send_free(32'd1024 * BLK_BYTES);    // past the last block
    send_free(32'hFFFF_FFFF);
    send_alloc(17'd65);                 // two blocks
    send_free(32'd64);                  // end mark
    send_alloc(17'd192);                // three blocks
    send_free(32'd3 * BLK_BYTES);       // inner used mark
    send_free(32'd2 * BLK_BYTES);
    send_free(32'd0);
    send_free(32'd512 * BLK_BYTES);
    drain_results();
  endtask

  task automatic test_heap_base();
    int unsigned keep_idx;
    logic [31:0] wrapped;
    write_heap_base(32'hFFFF_FFC0);
    keep_idx = ptr_m;
    wrapped  = base_m + keep_idx * BLK_BYTES;
    send_alloc(17'd64);                 // address wraps past 2^32
    send_free(wrapped);                 // now below base
    send_free(32'hFFFF_FFC0);           // block zero, free mark
    drain_results();
    write_heap_base(32'h0000_1000);
    send_free(32'h0000_1000 + keep_idx * BLK_BYTES);
    send_free(32'h0000_0FC0);           // below base
    send_free(32'hFFFF_FFC0);           // index far out of range
    drain_results();
    write_heap_base(32'd0);
  endtask

  task automatic test_backpressure();
    int unsigned n;
    logic [31:0] fa;
    hold_req = 1'b1;
    for (n = 0; n < 8; n++) send_alloc(17'($urandom_range(1, 256)));
    drain_results();
    for (n = 0; n < 8; n++) begin
      if (live_address(fa)) send_free(fa);
    end
    drain_results();
  endtask

  task automatic test_random(int unsigned count);
    int unsigned n;
    int unsigned pick;
    int unsigned sz;
    logic [31:0] fa;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      // keep the heap from clogging up
      if (used_m > 800 && pick < 55) pick = 60;
      if (pick < 55) begin
        sz = $urandom_range(99);
        if (sz < 80) send_alloc(17'($urandom_range(1, 256)));
        else if (sz < 95) send_alloc(17'($urandom_range(257, 4096)));
        else send_alloc(17'($urandom_range(4097, 131071)));
      end else if (pick < 90) begin
        if (live_address(fa)) send_free(fa);
        else send_alloc(17'($urandom_range(1, 256)));
      end else begin
        case ($urandom_range(3))
          0: send_alloc(17'd0);
          1: send_free($urandom);
          2: send_free(base_m + $urandom_range(0, 1100) * BLK_BYTES);
          default: begin
            if (live_address(fa)) send_free(fa + $urandom_range(1, 63));
            else send_free($urandom);
          end
        endcase
      end
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------- output side

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 35);
      end
    end
  end

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    alloc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0h addr %0h used %0h", $time,
                 m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[42:32]);
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, m_axis_tuser);
        check_field("alloc_address", want.addr, m_axis_tdata[31:0]);
        check_field("used_blocks", want.used, m_axis_tdata[42:32]);
        results_seen++;
        if (want.status <= bnfa_pkg::ST_FREE_IGN) status_count[want.status]++;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int unsigned i;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    errors        = 0;
    results_seen  = 0;
    for (i = 0; i < 5; i++) status_count[i] = 0;
    for (i = 0; i < NBLK; i++) blk_mark[i] = bnfa_pkg::MARK_FREE;
    ptr_m  = 0;
    used_m = 0;
    base_m = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_heap_base();
    test_backpressure();
    test_random(100);
    steady = 1'b1;
    write_heap_base($urandom & 32'h7FFF_FFC0);
    test_random(70);
    steady = 1'b0;
    write_heap_base(32'd0);
    test_random(80);

    drain_results();
    repeat (SLOW_CYCLES) @(posedge clk_i);
    $display("summary: %0d requests checked: %0d done, %0d zero size, %0d no space,",
             results_seen, status_count[bnfa_pkg::ST_DONE],
             status_count[bnfa_pkg::ST_ZERO_SIZE], status_count[bnfa_pkg::ST_NO_SPACE]);
    $display("summary: %0d no run, %0d ignored frees; bases low, mid, random, top",
             status_count[bnfa_pkg::ST_NO_RUN], status_count[bnfa_pkg::ST_FREE_IGN]);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
